// ===== design/brpr_pkg.sv =====
// ----------------------------------------------------------------------------
// brpr_pkg: shared types and constants of the breath peak rate estimator
// request structs, microcode words, the control store and slot arithmetic
// ----------------------------------------------------------------------------
package brpr_pkg;

  // ring of peak times
  localparam int unsigned PEAK_DEPTH     = 64;
  localparam int unsigned SLOT_W         = $clog2(PEAK_DEPTH);
  localparam int unsigned CNT_W          = $clog2(PEAK_DEPTH + 1);

  // rate format
  localparam int unsigned RATE_FRAC_BITS = 8;
  localparam int unsigned RATE_W         = 16;
  localparam logic [RATE_W-1:0] RATE_MAX = '1;
  localparam int unsigned CNT_SH_W       = CNT_W + RATE_FRAC_BITS;

  // field widths
  localparam int unsigned PRESS_W        = 16;
  localparam int unsigned TIME_W         = 32;
  localparam int unsigned WIN_W          = 20;
  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(60000);

  // interval divider: (60000 << frac) / interval
  localparam longint unsigned MS_PER_MINUTE = 60000;
  localparam longint unsigned DIVIDEND      = MS_PER_MINUTE << RATE_FRAC_BITS;
  localparam int unsigned DVD_W             = $clog2(DIVIDEND + 1);
  localparam int unsigned DIV_CNT_W         = $clog2(DVD_W);

  // rate kinds
  localparam logic [1:0] KIND_FEW      = 2'd0;
  localparam logic [1:0] KIND_INTERVAL = 2'd1;
  localparam logic [1:0] KIND_COUNT    = 2'd2;

  typedef struct packed {
    logic signed [PRESS_W-1:0] pressure;
    logic        [TIME_W-1:0]  time_ms;
  } in_item_t;

  typedef struct packed {
    logic [RATE_W-1:0] rate_q8;
    logic [1:0]        rate_kind;
    logic              peak_seen;
    logic              overflow;
  } out_item_t;

  // sequencer steps
  typedef enum logic [3:0] {
    S_IDLE      = 4'd0,
    S_PEAK      = 4'd1,
    S_POP_RD    = 4'd2,
    S_POP_CHK   = 4'd3,
    S_FIRST_RD  = 4'd4,
    S_FIRST_CHK = 4'd5,
    S_NEWEST    = 4'd6,
    S_PRIOR     = 4'd7,
    S_DIV       = 4'd8,
    S_SAT       = 4'd9,
    S_EMIT      = 4'd10
  } step_e;

  // datapath operations
  typedef enum logic [3:0] {
    UOP_IDLE,
    UOP_PEAK,
    UOP_POP_RD,
    UOP_POP_CHK,
    UOP_FIRST_RD,
    UOP_FIRST_CHK,
    UOP_NEWEST,
    UOP_PRIOR,
    UOP_DIV,
    UOP_SAT,
    UOP_EMIT
  } uop_e;

  // branch conditions
  typedef enum logic [3:0] {
    C_NONE,
    C_NO_IN,
    C_POP_SKIP,
    C_POP_HIT,
    C_FEW,
    C_WINDOW,
    C_NO_DIV,
    C_DIV_MORE,
    C_OUT_BUSY
  } cond_e;

  // one control word: op, branch on cond to target, else next or back to idle
  typedef struct packed {
    uop_e  op;
    cond_e cond;
    step_e target;
    logic  last;
  } ucode_t;

  function automatic ucode_t ucode_rom(step_e s);
    ucode_t w;
    unique case (s)
      S_IDLE:      w = '{UOP_IDLE,      C_NO_IN,    S_IDLE,     1'b0};
      S_PEAK:      w = '{UOP_PEAK,      C_NONE,     S_IDLE,     1'b0};
      S_POP_RD:    w = '{UOP_POP_RD,    C_POP_SKIP, S_FIRST_RD, 1'b0};
      S_POP_CHK:   w = '{UOP_POP_CHK,   C_POP_HIT,  S_POP_RD,   1'b0};
      S_FIRST_RD:  w = '{UOP_FIRST_RD,  C_FEW,      S_EMIT,     1'b0};
      S_FIRST_CHK: w = '{UOP_FIRST_CHK, C_WINDOW,   S_EMIT,     1'b0};
      S_NEWEST:    w = '{UOP_NEWEST,    C_NONE,     S_IDLE,     1'b0};
      S_PRIOR:     w = '{UOP_PRIOR,     C_NO_DIV,   S_EMIT,     1'b0};
      S_DIV:       w = '{UOP_DIV,       C_DIV_MORE, S_DIV,      1'b0};
      S_SAT:       w = '{UOP_SAT,       C_NONE,     S_IDLE,     1'b0};
      S_EMIT:      w = '{UOP_EMIT,      C_OUT_BUSY, S_EMIT,     1'b1};
      default:     w = '{UOP_IDLE,      C_NONE,     S_IDLE,     1'b1};
    endcase
    return w;
  endfunction

  // ring slot arithmetic, n never above the depth
  function automatic logic [SLOT_W-1:0] slot_add(logic [SLOT_W-1:0] s, logic [CNT_W-1:0] n);
    logic [SLOT_W:0] sum;
    sum = {1'b0, s} + (SLOT_W + 1)'(n);
    if (sum >= (SLOT_W + 1)'(PEAK_DEPTH)) begin
      sum = sum - (SLOT_W + 1)'(PEAK_DEPTH);
    end
    return SLOT_W'(sum);
  endfunction

endpackage

// ===== design/brpr_ram.sv =====
// ----------------------------------------------------------------------------
// brpr_ram: generic single-port-write, single-port-read ram
// one write and one registered read per cycle, no reset of the contents
// ----------------------------------------------------------------------------
module brpr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/breath_peak_rate_estimator.sv =====
// ----------------------------------------------------------------------------
// breath_peak_rate_estimator: peak detection and breath rate meter
// finds pressure peaks, keeps their times in a ring over a sliding window and
// reports a breath rate in fixed point, run by a microcoded sequencer
// ----------------------------------------------------------------------------
//
//  channel | signals                          | dir | moves
//  --------+----------------------------------+-----+---------------------------
//  in      | in_valid_i in_stall_o in_data_i  | in  | pressure, time_ms
//  out     | out_valid_o out_stall_i out_data_o| out | rate_q8, rate_kind, flags
//  cfg     | cfg_valid_i cfg_ready_o cfg_wdata_i| in | window_ms
//
//  one request at a time; the sequencer checks each expired peak in turn and,
//  when the rate comes from the last interval, runs the divider over the whole
//  dividend, doing less when the rate comes from the count or there are too
//  few peaks; the one-bit-a-cycle divider and the single ram read port set its
//  pace. a new request is taken only in the idle step; the finished result
//  sits in an output register, so the next request runs while it is stalled
//  reset clears control state; the ring contents are never cleared
// ----------------------------------------------------------------------------
module breath_peak_rate_estimator
  import brpr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // sample requests
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_data_i,
  // rate results
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_data_o,
  // window register
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [WIN_W-1:0] cfg_wdata_i
);

  // sequencer
  step_e  pc_q, pc_d;
  ucode_t cw;
  logic   cond_hit;

  // architectural state
  logic [WIN_W-1:0]          window_q, window_d;
  logic signed [PRESS_W-1:0] prev_q, prev_d;
  logic                      rising_q, rising_d;
  logic [SLOT_W-1:0]         oldest_q, oldest_d;
  logic [CNT_W-1:0]          count_q, count_d;

  // working registers of one request
  logic signed [PRESS_W-1:0] press_q, press_d;
  logic [TIME_W-1:0]         now_q, now_d;
  logic                      peak_q, peak_d;
  logic                      ovf_q, ovf_d;
  logic [RATE_W-1:0]         rate_q, rate_d;
  logic [1:0]                kind_q, kind_d;
  logic [TIME_W-1:0]         newest_q, newest_d;
  logic [TIME_W-1:0]         den_q, den_d;
  logic [TIME_W-1:0]         rem_q, rem_d;
  logic [DVD_W-1:0]          quo_q, quo_d;
  logic [DIV_CNT_W-1:0]      div_cnt_q, div_cnt_d;

  // output register
  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;

  // ring ram ports
  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  logic [SLOT_W-1:0] ram_raddr;
  logic [TIME_W-1:0] ram_rdata;

  // datapath terms
  logic              in_take;
  logic              is_peak;
  logic              ring_full;
  logic [SLOT_W-1:0] oldest_push;
  logic [CNT_W-1:0]  count_push;
  logic [CNT_W-1:0]  cnt_m1;
  logic [CNT_W-1:0]  cnt_m2;
  logic [TIME_W-1:0] win_ext;
  logic              pop_skip;
  logic              pop_hit;
  logic              few_peaks;
  logic              win_hit;
  logic              no_div;
  logic [TIME_W:0]   trial;
  logic [TIME_W:0]   trial_sub;
  logic              trial_ge;
  logic              div_more;
  logic              out_busy;
  logic [CNT_SH_W-1:0] cnt_shift;

  assign cw          = ucode_rom(pc_q);
  assign in_stall_o  = (pc_q != S_IDLE);
  assign in_take     = in_valid_i && (pc_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // peak detection and push slot, with the oldest time dropped on a full ring
  assign is_peak     = (press_q < prev_q) && rising_q;
  assign ring_full   = (count_q == CNT_W'(PEAK_DEPTH));
  assign oldest_push = ring_full ? slot_add(oldest_q, CNT_W'(1)) : oldest_q;
  assign count_push  = ring_full ? CNT_W'(PEAK_DEPTH - 1) : count_q;
  assign ram_waddr   = slot_add(oldest_push, count_push);
  assign ram_we      = (cw.op == UOP_PEAK) && is_peak;

  assign cnt_m1      = count_q - CNT_W'(1);
  assign cnt_m2      = count_q - CNT_W'(2);
  assign win_ext     = TIME_W'(window_q);

  // popping runs only once the window has fully elapsed since time zero
  assign pop_skip    = (now_q < win_ext) || (count_q == '0);
  assign pop_hit     = (ram_rdata < (now_q - win_ext));
  assign few_peaks   = (count_q < CNT_W'(2));
  assign win_hit     = (now_q >= ram_rdata) && ((now_q - ram_rdata) >= win_ext);
  assign no_div      = (newest_q <= ram_rdata);

  // restoring divider, one quotient bit per cycle
  assign trial       = {rem_q, quo_q[DVD_W-1]};
  assign trial_ge    = (trial >= {1'b0, den_q});
  assign trial_sub   = trial - {1'b0, den_q};
  assign div_more    = (div_cnt_q != DIV_CNT_W'(DVD_W - 1));

  assign out_busy    = out_valid_q && out_stall_i;
  assign cnt_shift   = CNT_SH_W'(count_q) << RATE_FRAC_BITS;

  // read address is chosen for the step that wants the data next, as the ram read is registered
  always_comb begin
    unique case (cw.op)
      UOP_FIRST_CHK: ram_raddr = slot_add(oldest_q, cnt_m1);
      UOP_NEWEST:    ram_raddr = slot_add(oldest_q, cnt_m2);
      default:       ram_raddr = oldest_q;
    endcase
  end

  // branch condition of the current control word
  always_comb begin
    unique case (cw.cond)
      C_NONE:     cond_hit = 1'b0;
      C_NO_IN:    cond_hit = !in_valid_i;
      C_POP_SKIP: cond_hit = pop_skip;
      C_POP_HIT:  cond_hit = pop_hit;
      C_FEW:      cond_hit = few_peaks;
      C_WINDOW:   cond_hit = win_hit;
      C_NO_DIV:   cond_hit = no_div;
      C_DIV_MORE: cond_hit = div_more;
      C_OUT_BUSY: cond_hit = out_busy;
      default:    cond_hit = 1'b0;
    endcase
  end

  // step counter: branch, else fall through or return to idle
  always_comb begin
    priority if (cond_hit) begin
      pc_d = cw.target;
    end else if (cw.last) begin
      pc_d = S_IDLE;
    end else begin
      pc_d = step_e'(pc_q + 4'd1);
    end
  end

  // datapath controlled by the op field
  always_comb begin
    window_d    = window_q;
    prev_d      = prev_q;
    rising_d    = rising_q;
    oldest_d    = oldest_q;
    count_d     = count_q;
    press_d     = press_q;
    now_d       = now_q;
    peak_d      = peak_q;
    ovf_d       = ovf_q;
    rate_d      = rate_q;
    kind_d      = kind_q;
    newest_d    = newest_q;
    den_d       = den_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    div_cnt_d   = div_cnt_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    if (cfg_valid_i) begin
      window_d = cfg_wdata_i;
    end

    unique case (cw.op)
      UOP_IDLE: begin
        if (in_take) begin
          press_d = in_data_i.pressure;
          now_d   = in_data_i.time_ms;
        end
      end
      UOP_PEAK: begin
        peak_d = 1'b0;
        ovf_d  = 1'b0;
        if (is_peak) begin
          oldest_d = oldest_push;
          count_d  = count_push + CNT_W'(1);
          ovf_d    = ring_full;
          peak_d   = 1'b1;
          rising_d = 1'b0;
        end else if (press_q > prev_q) begin
          rising_d = 1'b1;
        end
        prev_d = press_q;
      end
      UOP_POP_RD: begin
      end
      UOP_POP_CHK: begin
        // drop an expired time from the front
        if (pop_hit) begin
          oldest_d = slot_add(oldest_q, CNT_W'(1));
          count_d  = cnt_m1;
        end
      end
      UOP_FIRST_RD: begin
        rate_d = '0;
        kind_d = KIND_FEW;
      end
      UOP_FIRST_CHK: begin
        // oldest peak a full window back: report the count
        if (win_hit) begin
          kind_d = KIND_COUNT;
          rate_d = (cnt_shift > CNT_SH_W'(RATE_MAX)) ? RATE_MAX : RATE_W'(cnt_shift);
        end
      end
      UOP_NEWEST: begin
        newest_d = ram_rdata;
      end
      UOP_PRIOR: begin
        kind_d    = KIND_INTERVAL;
        rate_d    = (newest_q == ram_rdata) ? RATE_MAX : '0;
        den_d     = newest_q - ram_rdata;
        rem_d     = '0;
        quo_d     = DVD_W'(DIVIDEND);
        div_cnt_d = '0;
      end
      UOP_DIV: begin
        rem_d     = trial_ge ? trial_sub[TIME_W-1:0] : trial[TIME_W-1:0];
        quo_d     = {quo_q[DVD_W-2:0], trial_ge};
        div_cnt_d = div_cnt_q + DIV_CNT_W'(1);
      end
      UOP_SAT: begin
        rate_d = (quo_q > DVD_W'(RATE_MAX)) ? RATE_MAX : RATE_W'(quo_q);
      end
      UOP_EMIT: begin
        if (!out_busy) begin
          out_valid_d     = 1'b1;
          out_d.rate_q8   = rate_q;
          out_d.rate_kind = kind_q;
          out_d.peak_seen = peak_q;
          out_d.overflow  = ovf_q;
        end
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= S_IDLE;
      window_q    <= WINDOW_RESET;
      prev_q      <= '0;
      rising_q    <= 1'b0;
      oldest_q    <= '0;
      count_q     <= '0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      window_q    <= window_d;
      prev_q      <= prev_d;
      rising_q    <= rising_d;
      oldest_q    <= oldest_d;
      count_q     <= count_d;
      div_cnt_q   <= div_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    press_q  <= press_d;
    now_q    <= now_d;
    peak_q   <= peak_d;
    ovf_q    <= ovf_d;
    rate_q   <= rate_d;
    kind_q   <= kind_d;
    newest_q <= newest_d;
    den_q    <= den_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    out_q    <= out_d;
  end

  // ring of peak times
  brpr_ram #(
    .WIDTH (TIME_W),
    .DEPTH (PEAK_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (now_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // the ring never holds more peaks than it has slots
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(PEAK_DEPTH))
    else $error("peak count above ring depth");

  // a dropped time only comes with a new peak
  a_ovf_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!out_data_o.overflow || out_data_o.peak_seen))
    else $error("overflow without a peak");

  // too few peaks always reports a zero rate
  a_few_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.rate_kind == KIND_FEW)) |-> (out_data_o.rate_q8 == '0))
    else $error("nonzero rate with too few peaks");

  // the divider only ever runs on a positive interval
  a_div_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == S_DIV) |-> (den_q != '0))
    else $error("divider started on a zero interval");

endmodule

// ===== verif/breath_peak_rate_estimator_tb.sv =====
// ----------------------------------------------------------------------------
// breath_peak_rate_estimator_tb: self-checking bench for the breath rate meter
// drives pressure samples and window writes, predicts every rate result from
// its own ring of peak times and compares each one field by field
// ----------------------------------------------------------------------------
module breath_peak_rate_estimator_tb
  import brpr_pkg::*;
;

  // idling modes of the sample and result channels
  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  // scoreboard: a private copy of the estimator state and a queue of the rates
  // that accepted sample requests must produce, oldest first
  class rate_scoreboard;
    logic [WIN_W-1:0]          window_ms;
    logic signed [PRESS_W-1:0] last_pressure;
    bit                        rising;
    logic [TIME_W-1:0]         peak_ring [PEAK_DEPTH];
    int unsigned               head_slot;
    int unsigned               peak_total;
    out_item_t                 rate_q [$];
    int unsigned               mismatches;

    function void clear();
      window_ms     = WINDOW_RESET;
      last_pressure = '0;
      rising        = 1'b0;
      head_slot     = 0;
      peak_total    = 0;
      mismatches    = 0;
    endfunction

    // works out the result of one accepted sample request
    function void note_sample(in_item_t s);
      out_item_t         want;
      logic [TIME_W-1:0] now;
      logic [TIME_W-1:0] cutoff;
      logic [TIME_W-1:0] oldest_t;
      logic [TIME_W-1:0] newest_t;
      logic [TIME_W-1:0] prior_t;
      longint unsigned   rate;
      want = '0;
      now  = s.time_ms;
      // a fall after a rise closes a peak at this sample's time
      if ($signed(s.pressure) < last_pressure && rising) begin
        if (peak_total >= PEAK_DEPTH) begin
          head_slot     = (head_slot + 1) % PEAK_DEPTH;
          peak_total    = PEAK_DEPTH - 1;
          want.overflow = 1'b1;
        end
        peak_ring[(head_slot + peak_total) % PEAK_DEPTH] = now;
        peak_total++;
        rising         = 1'b0;
        want.peak_seen = 1'b1;
      end else if ($signed(s.pressure) > last_pressure) begin
        rising = 1'b1;
      end
      last_pressure = s.pressure;
      // expire peaks from the front, never when the clock is still early
      if (now >= TIME_W'(window_ms)) begin
        cutoff = now - TIME_W'(window_ms);
        while (peak_total > 0 && peak_ring[head_slot] < cutoff) begin
          head_slot = (head_slot + 1) % PEAK_DEPTH;
          peak_total--;
        end
      end
      if (peak_total < 2) begin
        want.rate_kind = KIND_FEW;
      end else begin
        oldest_t = peak_ring[head_slot];
        if (now >= oldest_t && now - oldest_t >= TIME_W'(window_ms)) begin
          want.rate_kind = KIND_COUNT;
          rate = longint'(peak_total) << RATE_FRAC_BITS;
        end else begin
          newest_t = peak_ring[(head_slot + peak_total - 1) % PEAK_DEPTH];
          prior_t  = peak_ring[(head_slot + peak_total - 2) % PEAK_DEPTH];
          want.rate_kind = KIND_INTERVAL;
          if (newest_t < prior_t) begin
            rate = 0;
          end else if (newest_t == prior_t) begin
            rate = RATE_MAX;
          end else begin
            rate = (MS_PER_MINUTE << RATE_FRAC_BITS) / longint'(newest_t - prior_t);
          end
        end
        want.rate_q8 = (rate > RATE_MAX) ? RATE_MAX : RATE_W'(rate);
      end
      rate_q.push_back(want);
    endfunction

    task report_mismatch(string what);
      $display("%0t mismatch: %s", $realtime, what);
      mismatches++;
    endtask

    task check_rate(out_item_t got);
      out_item_t want;
      if (rate_q.size() == 0) begin
        report_mismatch($sformatf("result %h with none outstanding", got));
        return;
      end
      want = rate_q.pop_front();
      if (got.rate_q8 !== want.rate_q8) begin
        report_mismatch($sformatf("rate_q8 got %0d want %0d", got.rate_q8, want.rate_q8));
      end
      if (got.rate_kind !== want.rate_kind) begin
        report_mismatch($sformatf("rate_kind got %0d want %0d", got.rate_kind,
                                  want.rate_kind));
      end
      if (got.peak_seen !== want.peak_seen) begin
        report_mismatch($sformatf("peak_seen got %b want %b", got.peak_seen,
                                  want.peak_seen));
      end
      if (got.overflow !== want.overflow) begin
        report_mismatch($sformatf("overflow got %b want %b", got.overflow, want.overflow));
      end
    endtask
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  in_item_t         in_data_i;
  logic             out_valid_o;
  logic             out_stall_i;
  out_item_t        out_data_o;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [WIN_W-1:0] cfg_wdata_i;

  rate_scoreboard   sb;
  int unsigned      send_idle_pct;
  int unsigned      recv_stall_pct;

  // breathing waveform state for the random part
  int               wave_level;
  bit               wave_up;
  logic [TIME_W-1:0] clock_ms;

  breath_peak_rate_estimator u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // result side back-pressure, redrawn every cycle
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // both monitors sample pre-edge values, so ordering within the step is moot
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        sb.check_rate(out_data_o);
      end
      if (in_valid_i && !in_stall_o) begin
        sb.note_sample(in_data_i);
      end
    end
  end

  task automatic set_idling(idle_mode_e mode);
    send_idle_pct  = (mode == IDLE_SENDER) ? 54 : (mode == IDLE_BOTH) ? 13 : 0;
    recv_stall_pct = (mode == IDLE_RECEIVER) ? 54 : (mode == IDLE_BOTH) ? 13 : 0;
  endtask

  // one sample request, held until the block takes it
  task automatic push_sample(logic signed [PRESS_W-1:0] p, logic [TIME_W-1:0] t);
    in_item_t it;
    it.pressure = p;
    it.time_ms  = t;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // one edge first so the monitor has logged the last accepted request
  task automatic wait_drained();
    @(posedge clk_i);
    while (sb.rate_q.size() != 0) @(posedge clk_i);
  endtask

  // window writes only once every outstanding rate has come back
  task automatic write_window(logic [WIN_W-1:0] w);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.window_ms = w;
    cfg_valid_i <= 1'b0;
  endtask

  // a noisy breathing signal: random rises and falls on a rising clock, with a
  // few arbitrary samples, some of them out of time order
  task automatic breathe_phase(int unsigned count, int unsigned max_step,
                               int unsigned flip_pct);
    int unsigned step;
    repeat (count) begin
      if ($urandom_range(99) < 8) begin
        push_sample(PRESS_W'($urandom), $urandom_range(1) ? $urandom : clock_ms);
      end else begin
        clock_ms += $urandom_range(max_step);
        if ($urandom_range(99) < flip_pct) begin
          wave_up = !wave_up;
        end
        // a flat sample now and then leaves the rising flag alone
        step = ($urandom_range(99) < 5) ? 0 : $urandom_range(1, 900);
        wave_level = wave_up ? wave_level + int'(step) : wave_level - int'(step);
        if (wave_level > 32767) begin
          wave_level = 32767;
          wave_up    = 1'b0;
        end else if (wave_level < -32768) begin
          wave_level = -32768;
          wave_up    = 1'b1;
        end
        push_sample(PRESS_W'(wave_level), clock_ms);
      end
    end
    in_valid_i <= 1'b0;
  endtask

  initial begin
    sb = new();
    sb.clear();
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    out_stall_i    = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_wdata_i    = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    wave_level     = 0;
    wave_up        = 1'b1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part under the reset window of one minute
    push_sample(0, 0);                  // flat start, no rise yet
    push_sample(100, 10);
    push_sample(50, 20);                // first peak, still too few
    push_sample(32767, 1000);
    push_sample(-32768, 1000);          // full swing, second peak
    push_sample(200, 1000);
    push_sample(100, 1000);             // same time as the last peak: saturates
    push_sample(300, 1010);
    push_sample(299, 1011);             // very short interval: saturates
    push_sample(500, 5000);
    push_sample(0, 9000);               // ordinary interval rate
    push_sample(10, 10000);
    push_sample(5, 10000);
    push_sample(6, 20000);
    push_sample(5, 20000);
    push_sample(7, 70000);              // pops old peaks, oldest exactly a window old
    push_sample(6, 70000);
    push_sample(8, 40000);
    push_sample(7, 30000);              // peak earlier than the one before it
    push_sample(9, 100);                // sample time before the oldest peak
    push_sample(9, 200);
    push_sample(10, 32'hFFFF_FFFF);     // latest time pops everything
    clock_ms = $urandom_range(2000);
    breathe_phase(110, 500, 35);

    // shortest nonzero window, sender idling
    write_window(1);
    set_idling(IDLE_SENDER);
    clock_ms = $urandom_range(2000);
    breathe_phase(110, 50, 40);

    // zero window pops anything older than now, receiver stalling
    write_window(0);
    set_idling(IDLE_RECEIVER);
    clock_ms = $urandom;
    breathe_phase(110, 20, 50);

    // widest window with dense peaks fills the ring and drops its oldest
    write_window('1);
    set_idling(IDLE_BOTH);
    clock_ms = $urandom_range(100000);
    breathe_phase(180, 30, 90);

    write_window(WIN_W'($urandom_range(1, (1 << WIN_W) - 1)));
    set_idling(IDLE_NONE);
    clock_ms = $urandom;
    breathe_phase(100, 2000, 35);

    // short window with the clock wrapping through zero
    write_window(3000);
    set_idling(IDLE_RECEIVER);
    clock_ms = 32'hFFFF_F000 + $urandom_range(4095);
    breathe_phase(100, 300, 50);

    // let stray results surface before the verdict
    wait_drained();
    repeat (200) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // hang guard, far above the slowest legal run
  initial begin
    #3000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== sim.f =====
design/brpr_pkg.sv
design/brpr_ram.sv
design/breath_peak_rate_estimator.sv
verif/breath_peak_rate_estimator_tb.sv
